// ===== rtl/core/cba_pkg.sv =====
// ----------------------------------------------------------------------------
// Contiguous block allocator package
// Shared constants, status codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package cba_pkg;

  localparam int unsigned BLOCKS_DEF  = 64;
  localparam int unsigned ID_BITS_DEF = 8;

  localparam logic [2:0] REQ_FIRST   = 3'd0;
  localparam logic [2:0] REQ_BEST    = 3'd1;
  localparam logic [2:0] REQ_WORST   = 3'd2;
  localparam logic [2:0] REQ_RELEASE = 3'd3;
  localparam logic [2:0] REQ_COMPACT = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOSPACE = 3'd1;
  localparam logic [2:0] ST_FRAG    = 3'd2;
  localparam logic [2:0] ST_EXISTS  = 3'd3;
  localparam logic [2:0] ST_MISSING = 3'd4;
  localparam logic [2:0] ST_COMPACT = 3'd5;
  localparam logic [2:0] ST_NOTHING = 3'd6;

  // Datapath operation selected by the controller for the running sweep.
  localparam logic [2:0] OP_IDLE  = 3'd0;
  localparam logic [2:0] OP_SCAN  = 3'd1;  // read pass: presence, holes, stats
  localparam logic [2:0] OP_FILL  = 3'd2;  // write owner over chosen hole
  localparam logic [2:0] OP_REL   = 3'd3;  // clear owner's first run
  localparam logic [2:0] OP_PACK  = 3'd4;  // move owned blocks down
  localparam logic [2:0] OP_ZERO  = 3'd5;  // clear tail after packing

  typedef struct packed {
    logic [2:0] op;
    logic       start;   // one-cycle pulse: restart the sweep counters
  } cba_cmd_t;

  typedef struct packed {
    logic done;          // current sweep finished
  } cba_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/contiguous_block_allocator.sv =====
// An allocation or a release runs a decision scan, then a fill or release sweep
// if it goes ahead, then a statistics scan; compaction packs and zeros the tail.
// Requests are taken one at a time, the next only once the last result is taken;
// the scan sweeps are paced by the single read port of the block map memory.
// Reset: synchronous, active low; a clearing pass over every block zeros the
// map, and requests are accepted only once it has finished.
// ----------------------------------------------------------------------------
// Contiguous block allocator
// First, best and worst fit allocation, release and compaction over a map.
// ----------------------------------------------------------------------------
`default_nettype none

module contiguous_block_allocator import cba_pkg::*; #(
  parameter int unsigned BLOCKS  = BLOCKS_DEF,
  parameter int unsigned ID_BITS = ID_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] in_req_type,
  input  wire logic [7:0] in_owner_id,
  input  wire logic [6:0] in_amount,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      out_status,
  output logic [6:0]      out_waste,
  output logic [6:0]      out_free_count,
  output logic [6:0]      out_largest_free,
  output logic [5:0]      out_hole_count
);

  localparam int unsigned CW_TOP = $clog2(BLOCKS + 1);

  cba_cmd_t   cmd;
  cba_sts_t   sts;
  logic [2:0] req_type;
  logic [7:0] owner_id;
  logic [6:0] amount;
  logic       id_found, fit_found, free_none, compacted, nfree_lt_amt;
  logic [6:0] waste, free_count, largest_free;
  logic [5:0] hole_count;
  logic       ctrl_ready;
  logic [CW_TOP-1:0] clr_cnt_r;
  logic       clr_done_r;

  // Mirrors the datapath's clearing pass so no request enters during it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_done_r <= 1'b0;
    end else if (!clr_done_r) begin
      clr_cnt_r <= clr_cnt_r + CW_TOP'(1);
      if (clr_cnt_r == CW_TOP'(BLOCKS - 1)) begin
        clr_done_r <= 1'b1;
      end
    end
  end

  assign in_ready = ctrl_ready && clr_done_r;

  cba_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid && clr_done_r),
    .in_ready        (ctrl_ready),
    .in_req_type     (in_req_type),
    .in_owner_id     (in_owner_id),
    .in_amount       (in_amount),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_waste       (out_waste),
    .out_free_count  (out_free_count),
    .out_largest_free(out_largest_free),
    .out_hole_count  (out_hole_count),
    .cmd             (cmd),
    .sts             (sts),
    .req_type        (req_type),
    .owner_id        (owner_id),
    .amount          (amount),
    .id_found        (id_found),
    .fit_found       (fit_found),
    .free_none       (free_none),
    .compacted       (compacted),
    .nfree_lt_amt    (nfree_lt_amt),
    .waste           (waste),
    .free_count      (free_count),
    .largest_free    (largest_free),
    .hole_count      (hole_count)
  );

  cba_dp #(.BLOCKS(BLOCKS), .ID_BITS(ID_BITS)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .req_type    (req_type),
    .owner_id    (owner_id),
    .amount      (amount),
    .id_found    (id_found),
    .fit_found   (fit_found),
    .free_none   (free_none),
    .compacted   (compacted),
    .waste       (waste),
    .free_count  (free_count),
    .largest_free(largest_free),
    .hole_count  (hole_count),
    .nfree_lt_amt(nfree_lt_amt)
  );

endmodule

`default_nettype wire

// ===== rtl/core/cba_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/cba_dp.sv =====
// ----------------------------------------------------------------------------
// Allocator datapath
// Block map memory, sweep counters, hole tracking and statistics.
// ----------------------------------------------------------------------------
`default_nettype none

module cba_dp import cba_pkg::*; #(
  parameter int unsigned BLOCKS  = BLOCKS_DEF,
  parameter int unsigned ID_BITS = ID_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire cba_cmd_t     cmd,
  output cba_sts_t          sts,
  input  wire logic [2:0]   req_type,
  input  wire logic [7:0]   owner_id,
  input  wire logic [6:0]   amount,
  output logic              id_found,
  output logic              fit_found,
  output logic              free_none,
  output logic              compacted,
  output logic [6:0]        waste,
  output logic [6:0]        free_count,
  output logic [6:0]        largest_free,
  output logic [5:0]        hole_count,
  output logic              nfree_lt_amt
);

  localparam int unsigned AW = $clog2(BLOCKS);
  localparam int unsigned CW = $clog2(BLOCKS + 1);
  localparam logic [CW-1:0] LAST = CW'(BLOCKS - 1);

  // Clearing pass marker: the map has no reset, so a sweep zeros it after reset.
  logic          clr_done_r;
  logic [CW-1:0] rd_cnt_r, rd_cnt_nxt;   // address issued
  logic          rv_r;                   // read data valid this cycle
  logic [AW-1:0] rv_idx_r;               // index of the data in rdata
  logic [CW-1:0] wr_ptr_r;               // write pointer (fill/pack/zero/clear)
  logic          busy_r;

  logic [ID_BITS-1:0] rdata;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [ID_BITS-1:0] wdata;
  logic [ID_BITS-1:0] id;

  // Scan results
  logic [CW-1:0] run_r, nfree_r, lg_r, hl_r;
  logic [CW-1:0] hstart_r;
  logic [CW-1:0] pick_pos_r, pick_len_r;
  logic          found_r, pres_r, rel_pos_ok_r, seen_free_r, moved_r;
  logic          rel_active_r;

  assign id = ID_BITS'(owner_id);

  cba_ram #(.WIDTH(ID_BITS), .DEPTH(BLOCKS)) u_map (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(rd_cnt_r[AW-1:0]),
    .rdata(rdata)
  );

  // Whether a closing hole of length len beats the pick of length plen (ties keep the earlier).
  function automatic logic better(input logic [2:0] m, input logic f,
                                  input logic [CW-1:0] len,
                                  input logic [CW-1:0] plen);
    logic r;
    begin
      r = !f || (m == REQ_BEST && len < plen) || (m == REQ_WORST && len > plen);
      return r;
    end
  endfunction

  logic          is_free;
  logic          last_rd;
  logic [CW-1:0] run_inc;
  logic          at_end;
  logic          first_mode;

  assign is_free   = (rdata == '0);
  assign last_rd   = rv_r && (rv_idx_r == LAST[AW-1:0]);
  assign run_inc   = run_r + CW'(1);
  assign first_mode = (req_type == REQ_FIRST);

  always_comb begin
    rd_cnt_nxt = rd_cnt_r + CW'(1);
  end

  // Write side
  always_comb begin
    we    = 1'b0;
    waddr = wr_ptr_r[AW-1:0];
    wdata = '0;
    if (!clr_done_r) begin
      we = 1'b1;
    end else if (busy_r) begin
      unique case (cmd.op)
        OP_FILL: begin
          we    = 1'b1;
          wdata = id;
        end
        OP_ZERO: we = 1'b1;
        OP_REL: begin
          we    = rv_r && rel_active_r && (rdata == id);
          waddr = rv_idx_r;
        end
        OP_PACK: begin
          we    = rv_r && !is_free;
          wdata = rdata;
        end
        default: we = 1'b0;
      endcase
    end
  end

  assign at_end = (wr_ptr_r == CW'(BLOCKS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_done_r <= 1'b0;
      wr_ptr_r   <= '0;
      busy_r     <= 1'b0;
      rv_r       <= 1'b0;
      rd_cnt_r   <= '0;
      sts.done   <= 1'b0;
    end else begin
      sts.done <= 1'b0;
      if (!clr_done_r) begin
        wr_ptr_r <= wr_ptr_r + CW'(1);
        if (wr_ptr_r == LAST) begin
          clr_done_r <= 1'b1;
        end
      end else if (cmd.start) begin
        busy_r   <= 1'b1;
        rd_cnt_r <= '0;
        rv_r     <= 1'b0;
        wr_ptr_r <= (cmd.op == OP_FILL) ? pick_pos_r :
                    (cmd.op == OP_ZERO) ? wr_ptr_r : '0;
      end else if (busy_r) begin
        unique case (cmd.op)
          OP_SCAN, OP_REL, OP_PACK: begin
            rv_r     <= (rd_cnt_r < CW'(BLOCKS));
            rv_idx_r <= rd_cnt_r[AW-1:0];
            if (rd_cnt_r < CW'(BLOCKS)) begin
              rd_cnt_r <= rd_cnt_nxt;
            end
            if (cmd.op == OP_PACK && rv_r && !is_free) begin
              wr_ptr_r <= wr_ptr_r + CW'(1);
            end
            if (last_rd) begin
              busy_r   <= 1'b0;
              sts.done <= 1'b1;
              rv_r     <= 1'b0;
            end
          end
          OP_FILL: begin
            wr_ptr_r <= wr_ptr_r + CW'(1);
            if (wr_ptr_r + CW'(1) == pick_pos_r + CW'(amount)) begin
              busy_r   <= 1'b0;
              sts.done <= 1'b1;
            end
          end
          OP_ZERO: begin
            if (at_end) begin
              busy_r   <= 1'b0;
              sts.done <= 1'b1;
            end else begin
              wr_ptr_r <= wr_ptr_r + CW'(1);
              if (wr_ptr_r == LAST) begin
                busy_r   <= 1'b0;
                sts.done <= 1'b1;
              end
            end
          end
          default: busy_r <= 1'b0;
        endcase
      end
    end
  end

  // Scan and statistics tracking over the read stream.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      run_r        <= '0;
      nfree_r      <= '0;
      lg_r         <= '0;
      hl_r         <= '0;
      found_r      <= 1'b0;
      pres_r       <= 1'b0;
      seen_free_r  <= 1'b0;
      moved_r      <= 1'b0;
      rel_active_r <= 1'b1;
      rel_pos_ok_r <= 1'b0;
      if (cmd.op == OP_SCAN) begin
        pick_pos_r <= '0;
        pick_len_r <= '0;
      end
    end else if (busy_r && rv_r && cmd.op == OP_REL) begin
      // Clear only the first consecutive run of the owner.
      if (rdata == id) begin
        rel_pos_ok_r <= 1'b1;
      end else if (rel_pos_ok_r) begin
        rel_active_r <= 1'b0;
      end
    end else if (busy_r && rv_r && cmd.op == OP_SCAN) begin
      if (rdata == id) begin
        pres_r <= 1'b1;
      end
      if (is_free) begin
        if (run_r == '0) begin
          hl_r     <= hl_r + CW'(1);
          hstart_r <= CW'(rv_idx_r);
        end
        run_r   <= run_inc;
        nfree_r <= nfree_r + CW'(1);
        if (run_inc > lg_r) begin
          lg_r <= run_inc;
        end
        seen_free_r <= 1'b1;
      end else begin
        run_r <= '0;
        if (seen_free_r) begin
          moved_r <= 1'b1;
        end
      end
      // A hole closes at an owned block or at the end of the map.
      if (is_free && last_rd) begin
        if (run_inc >= CW'(amount) && amount != '0 &&
            !(first_mode && found_r) &&
            better(req_type, found_r, run_inc, pick_len_r)) begin
          found_r    <= 1'b1;
          pick_pos_r <= (run_r == '0) ? CW'(rv_idx_r) : hstart_r;
          pick_len_r <= run_inc;
        end
      end else if (!is_free && run_r != '0) begin
        if (run_r >= CW'(amount) && amount != '0 &&
            !(first_mode && found_r) &&
            better(req_type, found_r, run_r, pick_len_r)) begin
          found_r    <= 1'b1;
          pick_pos_r <= hstart_r;
          pick_len_r <= run_r;
        end
      end
    end
  end

  function automatic logic [6:0] sat7(input logic [CW-1:0] v);
    return (v > CW'(127)) ? 7'd127 : 7'(v);
  endfunction

  assign id_found     = pres_r;
  assign fit_found    = found_r;
  assign free_none    = !seen_free_r;
  assign compacted    = !moved_r;
  assign nfree_lt_amt = nfree_r < CW'(amount);
  assign waste        = sat7(pick_len_r - CW'(amount));
  assign free_count   = sat7(nfree_r);
  assign largest_free = sat7(lg_r);
  assign hole_count   = (hl_r > CW'(63)) ? 6'd63 : 6'(hl_r);

  // The fill never runs past the end of the map.
  assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cmd.op == OP_FILL) |-> (wr_ptr_r < CW'(BLOCKS)))
    else $error("fill pointer past end of map");

  // Packing writes never overtake the read stream.
  assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cmd.op == OP_PACK && we) |-> (wr_ptr_r <= CW'(rv_idx_r)))
    else $error("pack write ahead of read");

  // The hole being filled always holds the request.
  assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cmd.op == OP_FILL) |-> (pick_len_r >= CW'(amount)))
    else $error("chosen hole too small");

endmodule

`default_nettype wire

// ===== rtl/core/cba_ctrl.sv =====
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences scan, fill, release and compaction sweeps for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module cba_ctrl import cba_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] in_req_type,
  input  wire logic [7:0] in_owner_id,
  input  wire logic [6:0] in_amount,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      out_status,
  output logic [6:0]      out_waste,
  output logic [6:0]      out_free_count,
  output logic [6:0]      out_largest_free,
  output logic [5:0]      out_hole_count,
  output cba_cmd_t        cmd,
  input  wire cba_sts_t   sts,
  output logic [2:0]      req_type,
  output logic [7:0]      owner_id,
  output logic [6:0]      amount,
  input  wire logic       id_found,
  input  wire logic       fit_found,
  input  wire logic       free_none,
  input  wire logic       compacted,
  input  wire logic       nfree_lt_amt,
  input  wire logic [6:0] waste,
  input  wire logic [6:0] free_count,
  input  wire logic [6:0] largest_free,
  input  wire logic [5:0] hole_count
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;  // decision scan
  localparam logic [2:0] S_WORK  = 3'd2;  // fill, release or pack
  localparam logic [2:0] S_ZERO  = 3'd3;
  localparam logic [2:0] S_STAT  = 3'd4;  // final statistics scan
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [2:0] op_r, op_nxt;
  logic       start_r, start_nxt;
  logic [2:0] status_r, status_nxt;
  logic [6:0] waste_r, waste_nxt;
  logic       outv_r, outv_nxt;
  logic [2:0] req_r;
  logic [7:0] id_r;
  logic [6:0] amt_r;
  logic       is_alloc;

  assign req_type = req_r;
  assign owner_id = id_r;
  assign amount   = amt_r;
  assign is_alloc = (req_r == REQ_FIRST) || (req_r == REQ_BEST) || (req_r == REQ_WORST);
  assign cmd       = {op_r, start_r};
  assign in_ready  = (state_r == S_IDLE) && !outv_r;
  assign out_valid = outv_r;
  assign out_status = status_r;
  assign out_waste  = waste_r;

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    start_nxt  = 1'b0;
    status_nxt = status_r;
    waste_nxt  = waste_r;
    outv_nxt   = outv_r;
    if (outv_r && out_ready) begin
      outv_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          state_nxt  = S_SCAN;
          op_nxt     = OP_SCAN;
          start_nxt  = 1'b1;
          status_nxt = ST_OK;
          waste_nxt  = '0;
        end
      end
      S_SCAN: begin
        if (sts.done) begin
          state_nxt = S_STAT;
          op_nxt    = OP_SCAN;
          start_nxt = 1'b1;
          priority if (is_alloc) begin
            if (id_r == '0 || id_found) begin
              status_nxt = ST_EXISTS;
            end else if (amt_r == '0) begin
              status_nxt = ST_NOSPACE;
            end else if (!fit_found) begin
              status_nxt = nfree_lt_amt ? ST_NOSPACE : ST_FRAG;
            end else begin
              waste_nxt = waste;
              state_nxt = S_WORK;
              op_nxt    = OP_FILL;
            end
          end else if (req_r == REQ_RELEASE) begin
            if (id_r == '0 || !id_found) begin
              status_nxt = ST_MISSING;
            end else begin
              state_nxt = S_WORK;
              op_nxt    = OP_REL;
            end
          end else if (req_r == REQ_COMPACT) begin
            if (free_none) begin
              status_nxt = ST_NOTHING;
            end else if (compacted) begin
              status_nxt = ST_COMPACT;
            end else begin
              state_nxt = S_WORK;
              op_nxt    = OP_PACK;
            end
          end else begin
            status_nxt = ST_OK;
          end
        end
      end
      S_WORK: begin
        if (sts.done) begin
          start_nxt = 1'b1;
          if (op_r == OP_PACK) begin
            state_nxt = S_ZERO;
            op_nxt    = OP_ZERO;
          end else begin
            state_nxt = S_STAT;
            op_nxt    = OP_SCAN;
          end
        end
      end
      S_ZERO: begin
        if (sts.done) begin
          state_nxt = S_STAT;
          op_nxt    = OP_SCAN;
          start_nxt = 1'b1;
        end
      end
      S_STAT: begin
        if (sts.done) begin
          state_nxt = S_OUT;
          op_nxt    = OP_IDLE;
        end
      end
      S_OUT: begin
        outv_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_IDLE;
      start_r <= 1'b0;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      start_r <= start_nxt;
      outv_r  <= outv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    waste_r  <= waste_nxt;
    if (in_valid && in_ready) begin
      req_r <= in_req_type;
      id_r  <= in_owner_id;
      amt_r <= in_amount;
    end
    if (state_r == S_OUT) begin
      out_free_count   <= free_count;
      out_largest_free <= largest_free;
      out_hole_count   <= hole_count;
    end
  end

  // Only one request in flight: no acceptance while a result is pending.
  assert property (@(posedge clk) disable iff (!rst_n)
    outv_r |-> !in_ready)
    else $error("input accepted while result pending");

  // A result appears only after the statistics sweep.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(outv_r) |-> $past(state_r) == S_OUT)
    else $error("result raised outside output state");

  // A sweep is launched on entry to the decision scan.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && state_nxt == S_SCAN) |=> start_r)
    else $error("scan not started");

endmodule

`default_nettype wire
